// ===== rtl/s2c_pkg.sv =====
`default_nettype none

package s2c_pkg;

    localparam int SAMPLE_W = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_USE_SCAN   = 2'd2;

    localparam logic signed [SAMPLE_W-1:0] RANGE_LOW_RESET  = 32'sd0;
    localparam logic signed [SAMPLE_W-1:0] RANGE_HIGH_RESET = 32'sd65536;

    localparam logic [7:0] INDEX_MAX       = 8'd255;
    localparam logic [7:0] CMAP_LINEAR_MAX = 8'd240;
    localparam logic [7:0] CMAP_KNEE       = 8'd241;
    localparam logic [7:0] NEG_BLUE_BOOST  = 8'd40;
    localparam logic [8:0] THIRD_RECIP     = 9'd171;

    typedef struct packed {
        logic load_in;
        logic calc_mag;
        logic prep;
        logic div_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_map;
        logic need_div;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // i/3 as a multiply by 171 and shift by 9, exact for 8-bit i
    function automatic rgb_t colormap(input logic [7:0] idx);
        rgb_t       c;
        logic [16:0] prod;
        logic [7:0]  third;
        logic [7:0]  upper;
        prod  = {9'd0, idx} * {8'd0, THIRD_RECIP};
        third = prod[16:9];
        upper = CMAP_KNEE + ((idx - CMAP_KNEE) >> 1);
        if (idx <= CMAP_LINEAR_MAX)
        begin
            c.r = third;
            c.g = idx;
            c.b = {third[6:0], 1'b0};
        end
        else
        begin
            c.r = upper;
            c.g = upper;
            c.b = upper;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/s2c_controller.sv =====
`default_nettype none

module s2c_controller (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  s2c_pkg::dp_status_t     status,
    output s2c_pkg::ctrl_cmd_t      cmd
);
    import s2c_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAG  = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_LOOK = 3'd4;

    localparam logic [2:0] DIV_LAST = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_MAG;
                end
            end
            S_MAG:
            begin
                cmd.calc_mag = 1'b1;
                state_next   = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep = 1'b1;
                cnt_next = '0;
                if (!status.is_map)
                    state_next = S_IDLE;
                else if (status.need_div)
                    state_next = S_DIV;
                else
                    state_next = S_LOOK;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 3'd1;
                if (cnt_reg == DIV_LAST)
                    state_next = S_LOOK;
            end
            S_LOOK:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && cnt_reg == DIV_LAST |=> state_reg == S_LOOK)
        else $error("division did not finish after eight steps");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE && in_valid |=> state_reg == S_MAG)
        else $error("accepted beat did not start processing");

    a_div_from_prep: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && cnt_reg == 3'd0 |-> $past(state_reg) == S_PREP)
        else $error("division entered without preparation");

endmodule

`default_nettype wire

// ===== rtl/s2c_datapath.sv =====
`default_nettype none

module s2c_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  s2c_pkg::ctrl_cmd_t              cmd,
    output s2c_pkg::dp_status_t             status,
    input  wire logic                       cfg_we,
    input  wire logic [s2c_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [s2c_pkg::SAMPLE_W-1:0]  cfg_data,
    input  wire logic                       operation,
    input  wire logic signed [s2c_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                       frame_start,
    output logic [7:0]                      red,
    output logic [7:0]                      green,
    output logic [7:0]                      blue,
    output logic [7:0]                      color_index,
    output logic                            range_error,
    output logic                            out_valid,
    input  wire logic                       out_stall
);
    import s2c_pkg::*;

    localparam logic signed [SAMPLE_W:0] ONE = $signed((SAMPLE_W+1)'(1) << FRAC_BITS);

    // configuration
    logic signed [SAMPLE_W-1:0] range_low_reg;
    logic signed [SAMPLE_W-1:0] range_high_reg;
    logic                       use_scan_reg;

    // scan tracking
    logic signed [SAMPLE_W-1:0] scan_min_reg;
    logic signed [SAMPLE_W-1:0] scan_max_reg;
    logic                       scan_valid_reg;

    // item in flight
    logic                       op_reg;
    logic                       start_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] m_reg;
    logic                       err_reg;
    logic [7:0]                 q_reg;
    logic [SAMPLE_W-1:0]        rem_reg;
    logic [7:0]                 numlow_reg;
    logic [SAMPLE_W-1:0]        den_reg;

    // result beat
    logic [7:0] red_reg, green_reg, blue_reg, index_reg;
    logic       err_out_reg;
    logic       out_valid_reg, out_valid_next;

    logic signed [SAMPLE_W:0]   sample_ext;
    logic signed [SAMPLE_W:0]   mag;
    logic signed [SAMPLE_W:0]   m_full;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    logic                       err;
    logic                       at_low;
    logic                       at_high;
    logic [SAMPLE_W:0]          a_wide;
    logic [SAMPLE_W:0]          den_wide;
    logic [SAMPLE_W+7:0]        num;
    logic [SAMPLE_W:0]          trial;
    logic [SAMPLE_W:0]          trial_sub;
    logic                       ge;
    rgb_t                       cmap;
    logic [8:0]                 blue_sum;
    logic [7:0]                 blue_adj;

    assign sample_ext = {sample_reg[SAMPLE_W-1], sample_reg};
    assign mag        = sample_reg[SAMPLE_W-1] ? -sample_ext : sample_ext;
    assign m_full     = mag - ONE;

    assign lo      = use_scan_reg ? scan_min_reg : range_low_reg;
    assign hi      = use_scan_reg ? scan_max_reg : range_high_reg;
    assign err     = !use_scan_reg && (lo >= hi);
    assign at_low  = (m_reg <= lo);
    assign at_high = (m_reg >= hi);

    assign a_wide   = {m_reg[SAMPLE_W-1], m_reg} - {lo[SAMPLE_W-1], lo};
    assign den_wide = {hi[SAMPLE_W-1], hi} - {lo[SAMPLE_W-1], lo};
    // times 255 as times 256 minus one
    assign num      = {a_wide[SAMPLE_W-1:0], 8'd0} - {8'd0, a_wide[SAMPLE_W-1:0]};

    assign trial     = {rem_reg, numlow_reg[7]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign ge        = (trial >= {1'b0, den_reg});

    assign cmap     = colormap(q_reg);
    assign blue_sum = {1'b0, cmap.b} + {1'b0, NEG_BLUE_BOOST};
    assign blue_adj = !sample_reg[SAMPLE_W-1] ? cmap.b :
                      (blue_sum[8] ? INDEX_MAX : blue_sum[7:0]);

    assign status.is_map   = op_reg;
    assign status.need_div = op_reg && !err && !at_low && !at_high;
    assign status.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= RANGE_LOW_RESET;
            range_high_reg <= RANGE_HIGH_RESET;
            use_scan_reg   <= 1'b1;
            scan_min_reg   <= '0;
            scan_max_reg   <= '0;
            scan_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RANGE_LOW:  range_low_reg  <= cfg_data;
                    REG_RANGE_HIGH: range_high_reg <= cfg_data;
                    REG_USE_SCAN:   use_scan_reg   <= cfg_data[0];
                    default:        ;
                endcase
            end
            if (cmd.prep && !op_reg)
            begin
                scan_valid_reg <= 1'b1;
                if (start_reg || !scan_valid_reg)
                begin
                    scan_min_reg <= m_reg;
                    scan_max_reg <= m_reg;
                end
                else
                begin
                    if (m_reg > scan_max_reg)
                        scan_max_reg <= m_reg;
                    if (m_reg < scan_min_reg)
                        scan_min_reg <= m_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg     <= operation;
            start_reg  <= frame_start;
            sample_reg <= sample;
        end
        if (cmd.calc_mag)
            m_reg <= m_full[SAMPLE_W-1:0];
        if (cmd.prep)
        begin
            err_reg    <= err;
            q_reg      <= (at_high && !at_low) ? INDEX_MAX : 8'd0;
            rem_reg    <= num[SAMPLE_W+7:8];
            numlow_reg <= num[7:0];
            den_reg    <= den_wide[SAMPLE_W-1:0];
        end
        if (cmd.div_step)
        begin
            rem_reg    <= ge ? trial_sub[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
            numlow_reg <= {numlow_reg[6:0], 1'b0};
            q_reg      <= {q_reg[6:0], ge};
        end
        if (cmd.load_out)
        begin
            red_reg     <= err_reg ? 8'd0 : cmap.r;
            green_reg   <= err_reg ? 8'd0 : cmap.g;
            blue_reg    <= err_reg ? 8'd0 : blue_adj;
            index_reg   <= err_reg ? 8'd0 : q_reg;
            err_out_reg <= err_reg;
        end
    end

    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign color_index = index_reg;
    assign range_error = err_out_reg;
    assign out_valid   = out_valid_reg;

    a_err_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && err_out_reg |->
            red_reg == 8'd0 && green_reg == 8'd0 && blue_reg == 8'd0 && index_reg == 8'd0)
        else $error("range error beat carries colour");

    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        scan_valid_reg |-> scan_min_reg <= scan_max_reg)
        else $error("scanned minimum above maximum");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> {1'b0, rem_reg} < {1'b0, den_reg})
        else $error("division remainder not below divisor");

endmodule

`default_nettype wire

// ===== rtl/scalar_to_colormap_pixel.sv =====
// scalar to colormap pixel
// input channel in_valid/in_stall carries operation, sample (signed fixed point,
// FRAC_BITS fraction bits) and frame_start; a scan beat updates the running
// min/max of |sample|-1.0 and gives no result, a map beat gives one result beat
// output channel out_valid/out_stall carries red, green, blue, color_index and
// range_error from an output register
// register writes via cfg_we/cfg_index/cfg_data only while the block is idle, a
// rule for the user that the block does not enforce; one item at a time: a scan
// beat passes acceptance, magnitude and prep; a map beat whose value lies inside
// the range adds 8 steps of a serial restoring divider and a lookup, a clamped or
// error map beat only the lookup, which loads the output register once it is
// free; the next item is accepted while a result still waits; if the receiver
// stalls and a second result is ready, the block holds it and keeps in_stall high
// reset clears scanned range, sets range_low 0, range_high 65536,
// use_scanned_range 1, and empties the output register
`default_nettype none

module scalar_to_colormap_pixel #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        operation,
    input  wire logic signed [31:0] sample,
    input  wire logic        frame_start,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic [7:0]       color_index,
    output logic             range_error
);
    import s2c_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    s2c_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    s2c_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .operation   (operation),
        .sample      (sample),
        .frame_start (frame_start),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .color_index (color_index),
        .range_error (range_error),
        .out_valid   (out_valid),
        .out_stall   (out_stall)
    );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    import s2c_pkg::*;

    localparam int FRAC_BITS    = 16;
    localparam longint ONE_FX   = longint'(1) << FRAC_BITS;
    localparam int DRAIN_CYCLES = 30;
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int N_DIRECTED   = 26;
    localparam int N_BLOCKS     = 10;
    localparam int BLOCK_ITEMS  = 100;

    typedef enum bit {OP_SCAN = 1'b0, OP_MAP = 1'b1} op_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] color_index;
        logic       range_error;
    } pixel_t;

    typedef struct packed {
        logic               cfg;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic               use_scan;
        op_t                op;
        logic signed [31:0] s;
        logic               fs;
        logic               typed;
        pixel_t             px;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = REG_RANGE_LOW;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic operation = OP_SCAN;
    logic signed [31:0] sample = '0;
    logic frame_start = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] color_index;
    logic range_error;

    pixel_t pending_pixels [$];
    int failures = 0;
    int cycle_count = 0;
    int gap_pct = 12;
    int stall_pct = 69;

    // colour model state
    longint fixed_lo = 0;
    longint fixed_hi = 65536;
    bit use_scan = 1'b1;
    longint scan_min = 0;
    longint scan_max = 0;
    bit scan_seen = 1'b0;

    scalar_to_colormap_pixel #(
        .FRAC_BITS(FRAC_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .sample(sample),
        .frame_start(frame_start),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .red(red),
        .green(green),
        .blue(blue),
        .color_index(color_index),
        .range_error(range_error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic pixel_t pix(input int r, input int g, input int b, input int i,
                                   input bit e);
        pixel_t p;
        p.red = r[7:0];
        p.green = g[7:0];
        p.blue = b[7:0];
        p.color_index = i[7:0];
        p.range_error = e;
        return p;
    endfunction

    dir_row_t directed_rows [N_DIRECTED] = '{
        // map before any scan: zero-width range at zero
        '{1'b0, 0, 0, 1'b1, OP_MAP, 'h0000_0000, 1'b0, 1'b1, pix(0, 0, 0, 0, 0)},
        '{1'b0, 0, 0, 1'b1, OP_MAP, 'h7fff_ffff, 1'b0, 1'b1, pix(248, 248, 248, 255, 0)},
        '{1'b0, 0, 0, 1'b1, OP_MAP, 'h8000_0000, 1'b0, 1'b1, pix(248, 248, 255, 255, 0)},
        // first scan restarts tracking without frame start
        '{1'b0, 0, 0, 1'b1, OP_SCAN, 'h0001_0000, 1'b0, 1'b0, '0},
        '{1'b0, 0, 0, 1'b1, OP_SCAN, 'h0005_0000, 1'b0, 1'b0, '0},
        '{1'b0, 0, 0, 1'b1, OP_SCAN, -'h0003_0000, 1'b0, 1'b0, '0},
        '{1'b0, 0, 0, 1'b1, OP_MAP, 'h0003_0000, 1'b1, 1'b0, '0},
        '{1'b0, 0, 0, 1'b1, OP_MAP, -'h0003_0000, 1'b0, 1'b0, '0},
        '{1'b0, 0, 0, 1'b1, OP_MAP, 'h0000_0000, 1'b0, 1'b1, pix(0, 0, 0, 0, 0)},
        // empty scanned range
        '{1'b0, 0, 0, 1'b1, OP_SCAN, 'h0002_0000, 1'b1, 1'b0, '0},
        '{1'b0, 0, 0, 1'b1, OP_MAP, 'h0002_0000, 1'b0, 1'b1, pix(0, 0, 0, 0, 0)},
        '{1'b0, 0, 0, 1'b1, OP_MAP, 'h0002_0001, 1'b0, 1'b1, pix(248, 248, 248, 255, 0)},
        // fixed range where index equals integer part of m
        '{1'b1, 0, 'h00ff_0000, 1'b0, OP_MAP, 'h00f1_0000, 1'b0, 1'b1,
          pix(80, 240, 160, 240, 0)},
        '{1'b0, 0, 0, 1'b0, OP_MAP, 'h00f2_0000, 1'b0, 1'b1, pix(241, 241, 241, 241, 0)},
        '{1'b0, 0, 0, 1'b0, OP_MAP, -'h00f2_0000, 1'b0, 1'b1, pix(241, 241, 255, 241, 0)},
        '{1'b0, 0, 0, 1'b0, OP_MAP, -'h0002_0000, 1'b0, 1'b1, pix(0, 1, 40, 1, 0)},
        '{1'b0, 0, 0, 1'b0, OP_MAP, 'h0004_0000, 1'b0, 1'b0, '0},
        '{1'b0, 0, 0, 1'b0, OP_MAP, 'h7fff_ffff, 1'b0, 1'b1, pix(248, 248, 248, 255, 0)},
        // invalid fixed ranges
        '{1'b1, 5, 5, 1'b0, OP_MAP, 'hffff_ffff, 1'b0, 1'b1, pix(0, 0, 0, 0, 1)},
        '{1'b1, 'h7fff_ffff, 'h8000_0000, 1'b0, OP_MAP, 12345, 1'b0, 1'b1, pix(0, 0, 0, 0, 1)},
        // widest fixed range
        '{1'b1, 'h8000_0000, 'h7fff_ffff, 1'b0, OP_MAP, 'h0000_0000, 1'b0, 1'b0, '0},
        '{1'b0, 0, 0, 1'b0, OP_MAP, 'h8000_0000, 1'b0, 1'b0, '0},
        '{1'b1, 0, 65536, 1'b1, OP_SCAN, 'h8000_0000, 1'b1, 1'b0, '0},
        '{1'b0, 0, 0, 1'b1, OP_SCAN, 'hffff_ffff, 1'b0, 1'b0, '0},
        '{1'b0, 0, 0, 1'b1, OP_MAP, 'h0000_8000, 1'b0, 1'b0, '0},
        '{1'b0, 0, 0, 1'b1, OP_MAP, 'h7fff_ffff, 1'b0, 1'b0, '0}
    };

    function automatic bit predict_pixel(input op_t op, input logic signed [31:0] s,
                                         input bit fs, output pixel_t px);
        longint m;
        longint lo;
        longint hi;
        longint q;
        int idx;
        int c;
        int b;
        m = ((s < 0) ? -longint'(s) : longint'(s)) - ONE_FX;
        px = '0;
        if (op == OP_SCAN)
        begin
            if (fs || !scan_seen)
            begin
                scan_min = m;
                scan_max = m;
                scan_seen = 1'b1;
            end
            else
            begin
                if (m > scan_max)
                    scan_max = m;
                if (m < scan_min)
                    scan_min = m;
            end
            return 1'b0;
        end
        if (use_scan)
        begin
            lo = scan_min;
            hi = scan_max;
        end
        else
        begin
            lo = fixed_lo;
            hi = fixed_hi;
            if (lo >= hi)
            begin
                px.range_error = 1'b1;
                return 1'b1;
            end
        end
        if (m <= lo)
            idx = 0;
        else if (m >= hi)
            idx = 255;
        else
        begin
            q = (m - lo) * 255 / (hi - lo);
            idx = (q > 255) ? 255 : int'(q);
        end
        if (idx <= 240)
        begin
            c = idx / 3;
            px.red = c[7:0];
            px.green = idx[7:0];
            b = 2 * c;
        end
        else
        begin
            c = 241 + (idx - 241) / 2;
            px.red = c[7:0];
            px.green = c[7:0];
            b = c;
        end
        if (s < 0)
            b = (b + 40 > 255) ? 255 : b + 40;
        px.blue = b[7:0];
        px.color_index = idx[7:0];
        return 1'b1;
    endfunction

    function automatic logic signed [31:0] rand_sample();
        logic signed [31:0] v;
        case ($urandom_range(19))
            0: v = 32'sh8000_0000;
            1: v = 32'sh7fff_ffff;
            2: v = 32'sh0001_0000;
            3: v = -32'sh0001_0000;
            4: v = '0;
            5, 6, 7, 8, 9: v = $urandom;
            default: v = $urandom_range(20 << FRAC_BITS) - (10 << FRAC_BITS);
        endcase
        return v;
    endfunction

    task automatic send_item(input op_t op, input logic signed [31:0] s, input bit fs,
                             input bit typed, input pixel_t typed_px);
        pixel_t px;
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        sample <= s;
        frame_start <= fs;
        do
            @(posedge clk);
        while (in_stall);
        if (predict_pixel(op, s, fs, px))
            pending_pixels.push_back(typed ? typed_px : px);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_ranges(input logic signed [31:0] lo, input logic signed [31:0] hi,
                              input bit scan);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= REG_RANGE_LOW;
        cfg_data <= lo;
        @(posedge clk);
        cfg_index <= REG_RANGE_HIGH;
        cfg_data <= hi;
        @(posedge clk);
        cfg_index <= REG_USE_SCAN;
        cfg_data <= {31'b0, scan};
        @(posedge clk);
        cfg_we <= 1'b0;
        fixed_lo = longint'(lo);
        fixed_hi = longint'(hi);
        use_scan = scan;
    endtask

    task automatic random_setting();
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        bit scan;
        case ($urandom_range(5))
            0, 1, 2:
            begin
                scan = 1'b1;
                lo = $urandom;
                hi = $urandom;
            end
            3:
            begin
                scan = 1'b0;
                lo = $urandom_range(6 << FRAC_BITS) - (2 << FRAC_BITS);
                hi = lo + $urandom_range(1, 12 << FRAC_BITS);
            end
            4:
            begin
                scan = 1'b0;
                lo = $urandom;
                hi = $urandom;
            end
            default:
            begin
                scan = 1'b0;
                if ($urandom_range(1))
                begin
                    lo = 32'sh8000_0000;
                    hi = 32'sh7fff_ffff;
                end
                else
                begin
                    lo = $urandom;
                    hi = lo;
                end
            end
        endcase
        set_ranges(lo, hi, scan);
    endtask

    // mostly frames: a scan with frame start, more scans, then maps; the rest is noise
    task automatic random_block(input int n_items);
        int sent;
        int n_scan;
        int n_map;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 15)
            begin
                send_item(op_t'($urandom_range(1)), rand_sample(), $urandom_range(1),
                          1'b0, '0);
                sent++;
            end
            else
            begin
                n_scan = $urandom_range(6);
                n_map = $urandom_range(1, 8);
                send_item(OP_SCAN, rand_sample(), $urandom_range(99) < 90, 1'b0, '0);
                repeat (n_scan)
                    send_item(OP_SCAN, rand_sample(), $urandom_range(99) < 5, 1'b0, '0);
                repeat (n_map)
                    send_item(OP_MAP, rand_sample(), $urandom_range(1), 1'b0, '0);
                sent += 1 + n_scan + n_map;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                failures++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (red !== want.red)
                begin
                    $error("red: expected %0d, got %0d", want.red, red);
                    failures++;
                end
                if (green !== want.green)
                begin
                    $error("green: expected %0d, got %0d", want.green, green);
                    failures++;
                end
                if (blue !== want.blue)
                begin
                    $error("blue: expected %0d, got %0d", want.blue, blue);
                    failures++;
                end
                if (color_index !== want.color_index)
                begin
                    $error("color_index: expected %0d, got %0d", want.color_index,
                           color_index);
                    failures++;
                end
                if (range_error !== want.range_error)
                begin
                    $error("range_error: expected %0d, got %0d", want.range_error,
                           range_error);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < N_DIRECTED; n++)
        begin
            if (directed_rows[n].cfg)
                set_ranges(directed_rows[n].lo, directed_rows[n].hi,
                           directed_rows[n].use_scan);
            send_item(directed_rows[n].op, directed_rows[n].s, directed_rows[n].fs,
                      directed_rows[n].typed, directed_rows[n].px);
        end

        for (int blk = 0; blk < N_BLOCKS; blk++)
        begin
            random_setting();
            if (blk < 3)
            begin
                gap_pct = 12;
                stall_pct <= 69;
            end
            else if (blk < 6)
            begin
                gap_pct = 69;
                stall_pct <= 12;
            end
            else
            begin
                gap_pct = 0;
                stall_pct <= 0;
            end
            random_block(BLOCK_ITEMS);
        end

        wait_idle();
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
